// ===== rtl/dcpp_pkg.sv =====
// dcpp_pkg: types and codes shared by the ping-pong receive buffer modules
// no dependencies
package dcpp_pkg;

  // command codes of an incoming request
  localparam logic [1:0] CMD_RECEIVE = 2'd0;
  localparam logic [1:0] CMD_QUERY   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // bit 7 of a received byte is dropped
  localparam logic [7:0] CHAR_MASK = 8'h7F;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  // request transfer
  typedef struct packed {
    logic [1:0] command;
    logic [1:0] channel;
    logic [7:0] rx_byte;
    logic [7:0] max_count;
  } request_t;

  // result transfer
  typedef struct packed {
    logic       data_valid;
    logic [6:0] data_byte;
    logic [7:0] count;
    logic       last;
  } result_t;

  // classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_READ,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] channel;
    logic [6:0] data;
    logic [7:0] max_count;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

// ===== rtl/dcpp_front.sv =====
// dcpp_front: accepts requests and classifies them into queue operations
// depends on dcpp_pkg
module dcpp_front #(
  parameter int CHANNELS = 2
) (
  input  logic              start,
  input  logic              full,
  input  dcpp_pkg::request_t request,
  output logic              push,
  output dcpp_pkg::entry_t  entry
);
  import dcpp_pkg::*;

  logic accept;
  logic ch_ok;
  logic keep;
  op_t  op;

  assign accept = start && !full;
  assign ch_ok  = ({1'b0, request.channel} < 3'(CHANNELS));

  // classify: invalid channels answer with zero, receives on them and the unused command vanish
  always_comb begin
    keep = 1'b1;
    op   = OP_ZERO;
    unique case (request.command)
      CMD_RECEIVE: begin
        op   = OP_WRITE;
        keep = ch_ok;
      end
      CMD_QUERY: op = ch_ok ? OP_QUERY : OP_ZERO;
      CMD_READ:  op = ch_ok ? OP_READ : OP_ZERO;
      default:   keep = 1'b0;
    endcase
  end

  assign push            = accept && keep;
  assign entry.op        = op;
  assign entry.channel   = request.channel;
  assign entry.data      = 7'(request.rx_byte & CHAR_MASK);
  assign entry.max_count = request.max_count;

endmodule

// ===== rtl/dcpp_queue.sv =====
// dcpp_queue: short in-order queue of classified operations
// depends on dcpp_pkg
module dcpp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dcpp_pkg::entry_t entry,
  input  logic             pop,
  output logic             head_valid,
  output dcpp_pkg::entry_t head,
  output logic             full
);
  import dcpp_pkg::*;

  entry_t               slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   used;

  assign head_valid = (used != '0);
  assign full       = (used == Q_CNT_W'(QUEUE_DEPTH));
  assign head       = slots[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) used <= used + 1'b1;
      else if (pop && !push) used <= used - 1'b1;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry;
  end

endmodule

// ===== rtl/dcpp_back.sv =====
// dcpp_back: buffer store, fill counts and result sequencing
// depends on dcpp_pkg
module dcpp_back #(
  parameter int BUFFER_DEPTH = 64,
  parameter int CHANNELS     = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  dcpp_pkg::entry_t  head,
  output logic              pop,
  output logic              strobe,
  output dcpp_pkg::result_t result
);
  import dcpp_pkg::*;

  localparam int MEM_DEPTH = CHANNELS * 2 * BUFFER_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int BUF_N     = 2 * CHANNELS;
  localparam int BUF_W     = $clog2(BUF_N);
  localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [6:0]          mem [MEM_DEPTH];
  logic [6:0]          mem_q;
  logic [CHANNELS-1:0] fill_select;
  logic [CNT_W-1:0]    fill_counts [BUF_N];
  state_t              state, state_next;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    rd_total;
  logic                res_dvalid;
  logic [7:0]          res_count;
  logic                res_last;

  logic [CH_W-1:0]     ch;
  logic                sel;
  logic [BUF_W-1:0]    fill_buf;
  logic [CNT_W-1:0]    fill_cnt;
  logic [ADDR_W-1:0]   fill_base;
  logic [ADDR_W-1:0]   wr_addr;
  logic [CNT_W-1:0]    take;
  logic                has_room;
  logic                do_write;
  logic                drain;
  logic                reply;

  // decode of the head operation
  assign ch        = head.channel[CH_W-1:0];
  assign sel       = fill_select[ch];
  assign fill_buf  = BUF_W'({head.channel, ~sel});
  assign fill_cnt  = fill_counts[fill_buf];
  assign fill_base = ADDR_W'(ADDR_W'(fill_buf) * ADDR_W'(BUFFER_DEPTH));
  assign wr_addr   = fill_base + ADDR_W'(fill_cnt);
  assign has_room  = (fill_cnt < CNT_W'(BUFFER_DEPTH));
  assign take      = (8'(fill_cnt) < head.max_count) ? fill_cnt : CNT_W'(head.max_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid && head.op == OP_READ && take != '0) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (rem == CNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    drain    = 1'b0;
    do_write = 1'b0;
    reply    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop      = head_valid;
        do_write = head_valid && head.op == OP_WRITE && has_room;
        reply    = head_valid && (head.op == OP_QUERY || head.op == OP_ZERO ||
                                  (head.op == OP_READ && take == '0));
      end
      ST_DRAIN: drain = 1'b1;
      default: ;
    endcase
  end

  // state, buffer selects, fill counts and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_select <= '0;
      strobe      <= 1'b0;
      for (int i = 0; i < BUF_N; i++) fill_counts[i] <= '0;
    end else begin
      state  <= state_next;
      strobe <= reply || drain;
      if (do_write) fill_counts[fill_buf] <= CNT_W'(fill_cnt + 1'b1);
      if (pop && head.op == OP_READ) begin
        fill_select[ch]       <= ~sel;
        fill_counts[fill_buf] <= '0;
      end
    end
  end

  // drain sequencing and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      res_dvalid <= 1'b0;
      res_last   <= 1'b1;
      res_count  <= (head.op == OP_QUERY) ? 8'(fill_cnt) : 8'd0;
      rd_addr    <= fill_base;
      rem        <= take;
      rd_total   <= take;
    end else if (drain) begin
      res_dvalid <= 1'b1;
      res_last   <= (rem == CNT_W'(1));
      res_count  <= 8'(rd_total);
      rd_addr    <= rd_addr + 1'b1;
      rem        <= rem - 1'b1;
    end
  end

  // character store write port
  always_ff @(posedge clk) begin
    if (do_write) mem[wr_addr] <= head.data;
  end

  // character store read port
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
  end

  assign result.data_valid = res_dvalid;
  assign result.data_byte  = res_dvalid ? mem_q : 7'd0;
  assign result.count      = res_count;
  assign result.last       = res_last;

endmodule

// ===== rtl/dual_channel_pingpong_rx_buffer_top.sv =====
// dual_channel_pingpong_rx_buffer_top: two-channel ping-pong receive buffer
// depends on dcpp_pkg, dcpp_front, dcpp_queue, dcpp_back
//
// usage
//   a request transfer happens at a clock edge with start high and busy low.
//   command receive stores a 7-bit character in the channel's fill buffer,
//   query returns the fill count, read swaps the two buffers of the channel
//   and returns up to max_count characters from the one just filled.
//   each result is shown for one cycle with strobe high; last marks the final
//   result of a request. the receiver cannot hold results off.
// timing
//   the front classifies requests into a two-entry queue; the back end works
//   through it, popping a receive or query once it heads the queue while
//   idle, so receives stream at 1 request per cycle while no read drains. a
//   query result passes a queue slot, then the strobe and result registers. a
//   read holds the back end for a setup step and then, if it delivers any,
//   for one character per cycle from the store's single read port. busy is
//   high while the queue holds 2 entries.
// reset
//   synchronous rst empties the queue, zeroes all fill counts and selects;
//   buffer contents are not cleared.
module dual_channel_pingpong_rx_buffer_top #(
  parameter int BUFFER_DEPTH = 64,
  parameter int CHANNELS     = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dcpp_pkg::request_t request,
  output logic               strobe,
  output dcpp_pkg::result_t  result
);
  import dcpp_pkg::*;

  logic   push;
  logic   pop;
  logic   full;
  logic   head_valid;
  entry_t entry;
  entry_t head;

  assign busy = full;

  // request classification
  dcpp_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .start  (start),
    .full   (full),
    .request(request),
    .push   (push),
    .entry  (entry)
  );

  // operation queue
  dcpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry     (entry),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head),
    .full      (full)
  );

  // buffer store and result sequencing
  dcpp_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .strobe    (strobe),
    .result    (result)
  );

  // results without a character always close their request
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.data_valid |-> result.last)
    else $error("result without data not marked last");

  // delivered characters carry a sensible count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe && result.data_valid |->
      result.count != 8'd0 && result.count <= 8'(BUFFER_DEPTH))
    else $error("read count out of range");

  // a read delivers its characters in consecutive cycles with a fixed count
  a_read_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && result.data_valid && !result.last |=>
      strobe && result.data_valid && result.count == $past(result.count))
    else $error("read burst broken");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for the two-channel ping-pong receive buffer
// depends on dcpp_pkg and dual_channel_pingpong_rx_buffer_top
module tb_top;
  import dcpp_pkg::*;

  localparam int BUFFER_DEPTH = 64;
  localparam int CHANNELS     = 2;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 1000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one row of the directed table
  typedef struct {
    request_t req;
    bit       typed;
    result_t  exp;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     strobe;
  request_t request;
  result_t  result;

  dual_channel_pingpong_rx_buffer_top #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .CHANNELS    (CHANNELS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .strobe (strobe),
    .result (result)
  );

  // shadow copy of the buffers, fill levels and ping-pong selects
  logic [6:0]  char_mem   [CHANNELS*2][BUFFER_DEPTH];
  int unsigned fill_level [CHANNELS*2];
  bit          fill_sel   [CHANNELS];

  result_t   predicted[$];
  result_t   pending_results[$];
  stim_row_t directed_rows[$];
  result_t   head;
  int        mismatches   = 0;
  int        stall_cycles = 0;
  int        items_sent   = 0;
  int        idle_odds    = 3;
  bit        idle_enable  = 1'b1;

  // clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic request_t make_req(input logic [1:0] cmd, input logic [1:0] ch,
                                        input logic [7:0] rx, input logic [7:0] want);
    request_t r;
    r.command   = cmd;
    r.channel   = ch;
    r.rx_byte   = rx;
    r.max_count = want;
    return r;
  endfunction

  // work out the results of one request and update the shadow state
  task automatic predict_request(input request_t req);
    int unsigned ch;
    int unsigned bank;
    int unsigned n;
    bit          ok;
    result_t     res;
    ch   = req.channel;
    ok   = ch < CHANNELS;
    n    = 0;
    bank = 0;
    res  = '0;
    res.last = 1'b1;
    predicted.delete();
    if (ok) bank = ch * 2 + int'(fill_sel[ch] ^ 1'b1);
    case (req.command)
      CMD_RECEIVE: begin
        // full fill buffer drops the byte
        if (ok && fill_level[bank] < BUFFER_DEPTH) begin
          char_mem[bank][fill_level[bank]] = 7'(req.rx_byte & CHAR_MASK);
          fill_level[bank]++;
        end
      end
      CMD_QUERY: begin
        if (ok) res.count = 8'(fill_level[bank]);
        predicted.push_back(res);
      end
      CMD_READ: begin
        if (ok) begin
          // swap, then drain the buffer that was just filled
          fill_sel[ch] = ~fill_sel[ch];
          bank = ch * 2 + int'(fill_sel[ch]);
          n = fill_level[bank];
          if (n > BUFFER_DEPTH) n = BUFFER_DEPTH;
          if (req.max_count < n) n = req.max_count;
          fill_level[bank] = 0;
          for (int i = 0; i < n; i++) begin
            res.data_valid = 1'b1;
            res.data_byte  = char_mem[bank][i];
            res.count      = 8'(n);
            res.last       = (i + 1 == n);
            predicted.push_back(res);
          end
        end
        // empty read or unknown channel gives a single empty result
        if (n == 0) predicted.push_back(res);
      end
      default: ;
    endcase
  endtask

  // one request transfer; typed rows replace the prediction with their own value
  task automatic send_request(input request_t req, input bit typed, input result_t exp);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    predict_request(req);
    if (typed) pending_results.push_back(exp);
    else foreach (predicted[i]) pending_results.push_back(predicted[i]);
    if (!(req.command == CMD_UNUSED || (req.command == CMD_RECEIVE && req.channel >= CHANNELS)))
      items_sent++;
    // random idle burst on the sending side
    if (idle_enable && $urandom_range(1, idle_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_plain(input request_t req);
    send_request(req, 1'b0, '0);
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [1:0] ch, input logic [7:0] rx,
                         input logic [7:0] want, input bit typed, input logic [7:0] cnt);
    stim_row_t row;
    row.req   = make_req(cmd, ch, rx, want);
    row.typed = typed;
    row.exp   = '0;
    row.exp.count = cnt;
    row.exp.last  = 1'b1;
    directed_rows.push_back(row);
  endtask

  // any command on any channel, including the unused code
  task automatic send_noise();
    send_plain(make_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                        8'($urandom), 8'($urandom)));
  endtask

  // mostly well-formed sequence: fill a channel (with occasional noise requests), maybe query, then swap and read
  task automatic run_fill_and_read(input bit overfill);
    int unsigned ch;
    int unsigned n;
    logic [7:0]  want;
    ch = $urandom_range(0, CHANNELS - 1);
    if (overfill) n = BUFFER_DEPTH + 3;
    else if ($urandom_range(0, 7) == 0) n = $urandom_range(40, BUFFER_DEPTH + 6);
    else n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_plain(make_req(CMD_RECEIVE, 2'(ch), 8'($urandom), 8'($urandom)));
    end
    if ($urandom_range(0, 1) == 1)
      send_plain(make_req(CMD_QUERY, 2'(ch), 8'($urandom), 8'($urandom)));
    case ($urandom_range(0, 4))
      0:       want = 8'hFF;
      1:       want = 8'($urandom);
      2:       want = 8'h00;
      default: want = 8'($urandom_range(0, n + 4));
    endcase
    if (overfill) want = 8'hFF;
    send_plain(make_req(CMD_READ, 2'(ch), 8'($urandom), want));
  endtask

  // result checker: receiver never stalls, so every strobe is a transfer
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: got valid=%0b byte=%02h count=%0d last=%0b",
                   result.data_valid, result.data_byte, result.count, result.last);
      end else begin
        head = pending_results.pop_front();
        if (head.data_valid !== result.data_valid || head.data_byte !== result.data_byte ||
            head.count !== result.count || head.last !== result.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"result mismatch: exp valid=%0b byte=%02h count=%0d last=%0b,",
                      " got valid=%0b byte=%02h count=%0d last=%0b"},
                     head.data_valid, head.data_byte, head.count, head.last,
                     result.data_valid, result.data_byte, result.count, result.last);
        end
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if ((start && !busy) || strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    bit first;
    int total;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    foreach (fill_level[i]) fill_level[i] = 0;
    foreach (fill_sel[i]) fill_sel[i] = 1'b0;

    // directed table: empty state, unknown channels, the unused command, masking, partial and zero reads
    add_row(CMD_QUERY,   2'd0, 8'h00, 8'h00, 1'b1, 8'd0);
    add_row(CMD_QUERY,   2'd1, 8'hFF, 8'hFF, 1'b1, 8'd0);
    add_row(CMD_READ,    2'd0, 8'h00, 8'hFF, 1'b1, 8'd0);
    add_row(CMD_QUERY,   2'd2, 8'h00, 8'h00, 1'b1, 8'd0);
    add_row(CMD_READ,    2'd3, 8'h00, 8'hFF, 1'b1, 8'd0);
    add_row(CMD_RECEIVE, 2'd2, 8'hFF, 8'h00, 1'b0, 8'd0);
    add_row(CMD_UNUSED,  2'd0, 8'hFF, 8'hFF, 1'b0, 8'd0);
    add_row(CMD_RECEIVE, 2'd0, 8'hFF, 8'h00, 1'b0, 8'd0);
    add_row(CMD_RECEIVE, 2'd0, 8'h80, 8'hFF, 1'b0, 8'd0);
    add_row(CMD_RECEIVE, 2'd0, 8'h00, 8'h00, 1'b0, 8'd0);
    add_row(CMD_RECEIVE, 2'd0, 8'h7F, 8'h00, 1'b0, 8'd0);
    add_row(CMD_QUERY,   2'd0, 8'h00, 8'h00, 1'b1, 8'd4);
    add_row(CMD_READ,    2'd0, 8'h00, 8'h02, 1'b0, 8'd0);
    add_row(CMD_QUERY,   2'd0, 8'h00, 8'h00, 1'b1, 8'd0);
    add_row(CMD_READ,    2'd0, 8'h00, 8'hFF, 1'b1, 8'd0);
    add_row(CMD_RECEIVE, 2'd1, 8'h55, 8'h00, 1'b0, 8'd0);
    add_row(CMD_RECEIVE, 2'd1, 8'hAA, 8'h00, 1'b0, 8'd0);
    add_row(CMD_READ,    2'd1, 8'h00, 8'h00, 1'b1, 8'd0);
    add_row(CMD_QUERY,   2'd1, 8'h00, 8'h00, 1'b1, 8'd0);
    add_row(CMD_RECEIVE, 2'd1, 8'h3C, 8'h00, 1'b0, 8'd0);
    add_row(CMD_RECEIVE, 2'd1, 8'hC3, 8'h00, 1'b0, 8'd0);
    add_row(CMD_QUERY,   2'd3, 8'h00, 8'h00, 1'b1, 8'd0);
    add_row(CMD_READ,    2'd1, 8'h00, 8'hFF, 1'b0, 8'd0);
    add_row(CMD_READ,    2'd2, 8'h00, 8'h00, 1'b1, 8'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].exp);

    // random part, opening with a fill past the buffer depth
    first = 1'b1;
    total = items_sent + RANDOM_ITEMS;
    while (items_sent < total) begin
      idle_enable = (items_sent < total - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      idle_odds   = $urandom_range(2, 6);
      if (first || $urandom_range(0, 4) != 0) run_fill_and_read(first);
      else send_noise();
      first = 1'b0;
    end

    // wait for every expected result, then let the pipeline settle
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
